// ===== rtl/bim_pkg.sv =====
// Shared definitions for the missing-aware bilinear interpolation unit.
// Holds the default widths and the control group that travels with each pipeline item.
// Depends on nothing.
package bim_pkg;

	// Default value width in bits and number of fraction bits of the offsets.
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Control that moves along the pipeline with every item.
	typedef struct packed {
		logic valid;
		logic miss;
	} ctl_t;

endpackage

// ===== rtl/bilinear_interp_missing_aware_unit.sv =====
// Missing-aware bilinear interpolation unit, fully pipelined.
// Throughput: one cell per cycle; busy is always low and the receiver cannot stall.
// The divider resolves one quotient bit per pipeline stage.
// Reset: arst_n clears all valid bits at once; no result appears until a new transfer.
// Depends on bim_pkg, bim_weights, bim_mac and bim_div.
module bilinear_interp_missing_aware_unit #(
	parameter int VALUE_WIDTH = bim_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = bim_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [FRAC_BITS:0]            frac_x,
	input  logic [FRAC_BITS:0]            frac_y,
	input  logic signed [VALUE_WIDTH-1:0] top_left,
	input  logic signed [VALUE_WIDTH-1:0] top_right,
	input  logic signed [VALUE_WIDTH-1:0] bottom_left,
	input  logic signed [VALUE_WIDTH-1:0] bottom_right,
	input  logic                          top_left_missing,
	input  logic                          top_right_missing,
	input  logic                          bottom_left_missing,
	input  logic                          bottom_right_missing,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] result_value,
	output logic                          result_missing
);

	localparam int VW = VALUE_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int WW = 2*F + 1;

	// The pipeline never stalls, so every start is a transfer.
	assign busy = 1'b0;

	bim_pkg::ctl_t ctl_s2, ctl_s6, ctl_dv;
	logic [WW-1:0] w_tl_s2, w_tr_s2, w_bl_s2, w_br_s2, d_s2, d_s6, d_dv, rem_dv;
	logic [VW-1:0] v_tl_s2, v_tr_s2, v_bl_s2, v_br_s2, q_dv;
	logic [VW+2*F-1:0] mag_s6;
	logic neg_s6, neg_dv;

	bim_weights #(.VW(VW), .F(F)) u_weights (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.frac_x(frac_x), .frac_y(frac_y),
		.v_tl(top_left), .v_tr(top_right), .v_bl(bottom_left), .v_br(bottom_right),
		.m_tl(top_left_missing), .m_tr(top_right_missing),
		.m_bl(bottom_left_missing), .m_br(bottom_right_missing),
		.ctl_s2(ctl_s2),
		.w_tl_s2(w_tl_s2), .w_tr_s2(w_tr_s2), .w_bl_s2(w_bl_s2), .w_br_s2(w_br_s2),
		.d_s2(d_s2),
		.v_tl_s2(v_tl_s2), .v_tr_s2(v_tr_s2), .v_bl_s2(v_bl_s2), .v_br_s2(v_br_s2)
	);

	bim_mac #(.VW(VW), .F(F)) u_mac (
		.clk(clk), .arst_n(arst_n), .ctl_in(ctl_s2),
		.w_tl(w_tl_s2), .w_tr(w_tr_s2), .w_bl(w_bl_s2), .w_br(w_br_s2), .d_in(d_s2),
		.v_tl(v_tl_s2), .v_tr(v_tr_s2), .v_bl(v_bl_s2), .v_br(v_br_s2),
		.ctl_s6(ctl_s6), .mag_s6(mag_s6), .neg_s6(neg_s6), .d_s6(d_s6)
	);

	bim_div #(.VW(VW), .F(F)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl_in(ctl_s6),
		.mag_in(mag_s6), .neg_in(neg_s6), .d_in(d_s6),
		.ctl_out(ctl_dv), .q_out(q_dv), .rem_out(rem_dv), .neg_out(neg_dv), .d_out(d_dv)
	);

	// Round to nearest with ties away from zero, then saturate and restore the sign.
	localparam logic [VW:0] LIM_POS = {2'b00, {(VW-1){1'b1}}};
	localparam logic [VW:0] LIM_NEG = {2'b01, {(VW-1){1'b0}}};

	logic          round_up;
	logic [VW:0]   q_rnd, lim, q_sat;
	logic [VW-1:0] val;

	assign round_up = ({rem_dv, 1'b0} >= {1'b0, d_dv});
	assign q_rnd    = {1'b0, q_dv} + {{VW{1'b0}}, round_up};
	assign lim      = neg_dv ? LIM_NEG : LIM_POS;
	assign q_sat    = (q_rnd > lim) ? lim : q_rnd;
	assign val      = neg_dv ? (VW'(0) - q_sat[VW-1:0]) : q_sat[VW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= ctl_dv.valid;
	end

	always_ff @(posedge clk) begin
		result_missing <= ctl_dv.miss;
		result_value   <= ctl_dv.miss ? '0 : $signed(val);
	end

endmodule

// ===== rtl/bim_weights.sv =====
// Front end: offset clamping, corner weights and missing-corner decode (two stages).
// Depends on bim_pkg.
module bim_weights #(
	parameter int VW = bim_pkg::VALUE_WIDTH_DEF,
	parameter int F  = bim_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [F:0]          frac_x,
	input  logic [F:0]          frac_y,
	input  logic [VW-1:0]       v_tl,
	input  logic [VW-1:0]       v_tr,
	input  logic [VW-1:0]       v_bl,
	input  logic [VW-1:0]       v_br,
	input  logic                m_tl,
	input  logic                m_tr,
	input  logic                m_bl,
	input  logic                m_br,
	output bim_pkg::ctl_t       ctl_s2,
	output logic [2*F:0]        w_tl_s2,
	output logic [2*F:0]        w_tr_s2,
	output logic [2*F:0]        w_bl_s2,
	output logic [2*F:0]        w_br_s2,
	output logic [2*F:0]        d_s2,
	output logic [VW-1:0]       v_tl_s2,
	output logic [VW-1:0]       v_tr_s2,
	output logic [VW-1:0]       v_bl_s2,
	output logic [VW-1:0]       v_br_s2
);

	localparam int WW = 2*F + 1;
	localparam logic [F:0]    ONE_F = {1'b1, {F{1'b0}}};
	localparam logic [WW-1:0] ONE2  = {1'b1, {(2*F){1'b0}}};

	typedef struct packed {
		logic [WW-1:0] wa;
		logic [WW-1:0] wb;
		logic          miss;
	} side_t;

	// Weights of a 1-D blend along one cell edge, scaled to the full divisor.
	function automatic side_t edge_w(input logic [F:0] f, input logic [F:0] omf,
		input logic ma, input logic mb);
		side_t e;
		e.wa = '0;
		e.wb = '0;
		e.miss = 1'b0;
		if (ma) begin
			if (f != ONE_F || mb) e.miss = 1'b1;
			else e.wb = ONE2;
		end else if (mb) begin
			if (f != '0) e.miss = 1'b1;
			else e.wa = ONE2;
		end else begin
			e.wa = {omf, {F{1'b0}}};
			e.wb = {f, {F{1'b0}}};
		end
		return e;
	endfunction

	// Stage 1: clamp offsets and form the four bilinear weights.
	logic [F:0] dx, dy, omx, omy;
	logic [2*F+1:0] p_bl, p_br, p_tl, p_tr;
	assign dx  = (frac_x > ONE_F) ? ONE_F : frac_x;
	assign dy  = (frac_y > ONE_F) ? ONE_F : frac_y;
	assign omx = ONE_F - dx;
	assign omy = ONE_F - dy;
	assign p_bl = omx * omy;
	assign p_br = dx * omy;
	assign p_tl = omx * dy;
	assign p_tr = dx * dy;

	logic              valid_s1;
	logic [F:0]        dx_s1, dy_s1, omx_s1, omy_s1;
	logic [WW-1:0]     w_bl_s1, w_br_s1, w_tl_s1, w_tr_s1;
	logic [VW-1:0]     v_tl_s1, v_tr_s1, v_bl_s1, v_br_s1;
	logic              m_tl_s1, m_tr_s1, m_bl_s1, m_br_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		dx_s1   <= dx;
		dy_s1   <= dy;
		omx_s1  <= omx;
		omy_s1  <= omy;
		w_bl_s1 <= p_bl[WW-1:0];
		w_br_s1 <= p_br[WW-1:0];
		w_tl_s1 <= p_tl[WW-1:0];
		w_tr_s1 <= p_tr[WW-1:0];
		v_tl_s1 <= v_tl;
		v_tr_s1 <= v_tr;
		v_bl_s1 <= v_bl;
		v_br_s1 <= v_br;
		m_tl_s1 <= m_tl;
		m_tr_s1 <= m_tr;
		m_bl_s1 <= m_bl;
		m_br_s1 <= m_br;
	end

	// Stage 2: choose the blend from the missing pattern and the cell edges.
	logic [WW-1:0] w_bl, w_br, w_tl, w_tr, d;
	logic          miss;

	always_comb begin
		side_t e;
		logic [2:0] cnt;
		logic [WW-1:0] wm;
		w_bl = '0;
		w_br = '0;
		w_tl = '0;
		w_tr = '0;
		d    = ONE2;
		miss = 1'b0;
		cnt  = 3'(m_tl_s1) + 3'(m_tr_s1) + 3'(m_bl_s1) + 3'(m_br_s1);
		e    = '0;
		wm   = '0;
		if (cnt == 3'd0) begin
			w_bl = w_bl_s1;
			w_br = w_br_s1;
			w_tl = w_tl_s1;
			w_tr = w_tr_s1;
		end else if (dy_s1 == '0) begin
			e = edge_w(dx_s1, omx_s1, m_bl_s1, m_br_s1);
			w_bl = e.wa;
			w_br = e.wb;
			miss = e.miss;
		end else if (dy_s1 == ONE_F) begin
			e = edge_w(dx_s1, omx_s1, m_tl_s1, m_tr_s1);
			w_tl = e.wa;
			w_tr = e.wb;
			miss = e.miss;
		end else if (dx_s1 == '0) begin
			e = edge_w(dy_s1, omy_s1, m_bl_s1, m_tl_s1);
			w_bl = e.wa;
			w_tl = e.wb;
			miss = e.miss;
		end else if (dx_s1 == ONE_F) begin
			e = edge_w(dy_s1, omy_s1, m_br_s1, m_tr_s1);
			w_br = e.wa;
			w_tr = e.wb;
			miss = e.miss;
		end else if (cnt == 3'd1) begin
			// The weights sum to one, so the remaining weight is one minus the lost one.
			w_bl = m_bl_s1 ? '0 : w_bl_s1;
			w_br = m_br_s1 ? '0 : w_br_s1;
			w_tl = m_tl_s1 ? '0 : w_tl_s1;
			w_tr = m_tr_s1 ? '0 : w_tr_s1;
			wm = m_bl_s1 ? w_bl_s1 : m_br_s1 ? w_br_s1 : m_tl_s1 ? w_tl_s1 : w_tr_s1;
			d = ONE2 - wm;
			miss = (d == '0);
		end else begin
			miss = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s2 <= '0;
		else ctl_s2 <= '{valid: valid_s1, miss: miss};
	end

	always_ff @(posedge clk) begin
		w_bl_s2 <= w_bl;
		w_br_s2 <= w_br;
		w_tl_s2 <= w_tl;
		w_tr_s2 <= w_tr;
		d_s2    <= d;
		v_tl_s2 <= v_tl_s1;
		v_tr_s2 <= v_tr_s1;
		v_bl_s2 <= v_bl_s1;
		v_br_s2 <= v_br_s1;
	end

endmodule

// ===== rtl/bim_mac.sv =====
// Weighted sum of the four corners and its sign/magnitude split (four stages).
// Depends on bim_pkg.
module bim_mac #(
	parameter int VW = bim_pkg::VALUE_WIDTH_DEF,
	parameter int F  = bim_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bim_pkg::ctl_t          ctl_in,
	input  logic [2*F:0]           w_tl,
	input  logic [2*F:0]           w_tr,
	input  logic [2*F:0]           w_bl,
	input  logic [2*F:0]           w_br,
	input  logic [2*F:0]           d_in,
	input  logic [VW-1:0]          v_tl,
	input  logic [VW-1:0]          v_tr,
	input  logic [VW-1:0]          v_bl,
	input  logic [VW-1:0]          v_br,
	output bim_pkg::ctl_t          ctl_s6,
	output logic [VW+2*F-1:0]      mag_s6,
	output logic                   neg_s6,
	output logic [2*F:0]           d_s6
);

	localparam int WW = 2*F + 1;
	localparam int AW = VW + WW;
	localparam int MW = VW + 2*F;

	// Stage 3: one signed product per corner.
	logic signed [AW:0] pr_tl, pr_tr, pr_bl, pr_br;
	assign pr_tl = $signed(v_tl) * $signed({1'b0, w_tl});
	assign pr_tr = $signed(v_tr) * $signed({1'b0, w_tr});
	assign pr_bl = $signed(v_bl) * $signed({1'b0, w_bl});
	assign pr_br = $signed(v_br) * $signed({1'b0, w_br});

	bim_pkg::ctl_t ctl_s3, ctl_s4, ctl_s5;
	logic [WW-1:0] d_s3, d_s4, d_s5;
	logic [AW-1:0] p_tl_s3, p_tr_s3, p_bl_s3, p_br_s3;
	logic [AW-1:0] sum_b_s4, sum_t_s4, acc_s5;
	logic [AW-1:0] acc_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			ctl_s3 <= ctl_in;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	// Magnitude of the total; it always fits one bit below the accumulator width.
	assign acc_abs = acc_s5[AW-1] ? (AW'(0) - acc_s5) : acc_s5;

	always_ff @(posedge clk) begin
		p_tl_s3  <= pr_tl[AW-1:0];
		p_tr_s3  <= pr_tr[AW-1:0];
		p_bl_s3  <= pr_bl[AW-1:0];
		p_br_s3  <= pr_br[AW-1:0];
		d_s3     <= d_in;
		// Stage 4: pairwise sums.
		sum_b_s4 <= p_bl_s3 + p_br_s3;
		sum_t_s4 <= p_tl_s3 + p_tr_s3;
		d_s4     <= d_s3;
		// Stage 5: total.
		acc_s5   <= sum_b_s4 + sum_t_s4;
		d_s5     <= d_s4;
		// Stage 6: sign and magnitude.
		neg_s6   <= acc_s5[AW-1];
		mag_s6   <= acc_abs[MW-1:0];
		d_s6     <= d_s5;
	end

endmodule

// ===== rtl/bim_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bim_pkg.
module bim_div #(
	parameter int VW = bim_pkg::VALUE_WIDTH_DEF,
	parameter int F  = bim_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bim_pkg::ctl_t          ctl_in,
	input  logic [VW+2*F-1:0]      mag_in,
	input  logic                   neg_in,
	input  logic [2*F:0]           d_in,
	output bim_pkg::ctl_t          ctl_out,
	output logic [VW-1:0]          q_out,
	output logic [2*F:0]           rem_out,
	output logic                   neg_out,
	output logic [2*F:0]           d_out
);

	localparam int DW = 2*F + 1;

	// Index zero is the stage input; the quotient bits shift in where numerator bits leave.
	bim_pkg::ctl_t  ctl_s [0:VW];
	logic [DW-1:0]  rem_s [0:VW];
	logic [VW-1:0]  nq_s  [0:VW];
	logic [DW-1:0]  d_s   [0:VW];
	logic           neg_s [0:VW];
	logic           ovf_s [0:VW];

	assign ctl_s[0] = ctl_in;
	assign rem_s[0] = {1'b0, mag_in[VW+2*F-1:VW]};
	assign nq_s[0]  = mag_in[VW-1:0];
	assign d_s[0]   = d_in;
	assign neg_s[0] = neg_in;
	// When the upper half of the numerator already reaches the divisor, the quotient
	// does not fit the result width and the value must saturate.
	assign ovf_s[0] = (rem_s[0] >= d_in);

	for (genvar i = 0; i < VW; i++) begin : g_step
		logic [DW:0] t, diff;
		logic        ge;
		assign t    = {rem_s[i], nq_s[i][VW-1]};
		assign diff = t - {1'b0, d_s[i]};
		assign ge   = (t >= {1'b0, d_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[i+1] <= '0;
			else ctl_s[i+1] <= ctl_s[i];
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
			nq_s[i+1]  <= {nq_s[i][VW-2:0], ge};
			d_s[i+1]   <= d_s[i];
			neg_s[i+1] <= neg_s[i];
			ovf_s[i+1] <= ovf_s[i];
		end
	end

	// An oversized quotient leaves as all ones with no remainder, so it saturates.
	assign ctl_out = ctl_s[VW];
	assign q_out   = ovf_s[VW] ? '1 : nq_s[VW];
	assign rem_out = ovf_s[VW] ? '0 : rem_s[VW];
	assign neg_out = neg_s[VW];
	assign d_out   = d_s[VW];

	// A value-bearing item never divides by zero.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_in.valid && !ctl_in.miss |-> d_in != '0)
		else $error("divider entered with zero divisor");

	// The final remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_out.valid && !ctl_out.miss |-> rem_out < d_out)
		else $error("divider remainder out of range");

	// Every item leaves exactly after the divider depth.
	a_depth_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_in.valid |-> ##(VW) ctl_out.valid)
		else $error("divider lost an item");

	a_depth_back: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_out.valid |-> $past(ctl_in.valid, VW))
		else $error("divider invented an item");

endmodule

// ===== verif/bilinear_interp_missing_aware_unit_tb.sv =====
// Self-checking testbench for the missing-aware bilinear interpolation unit.
// Predicts each result with an internal fixed-point model and checks every done strobe.
// Depends on bim_pkg and the unit under test.
module bilinear_interp_missing_aware_unit_tb;

	localparam int VW = bim_pkg::VALUE_WIDTH_DEF;
	localparam int FB = bim_pkg::FRAC_BITS_DEF;
	localparam longint unsigned UNIT = 64'd1 << FB;
	localparam logic [FB:0] OFS_ONE = {1'b1, {FB{1'b0}}};
	localparam int LATENCY = VW + 7;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [FB:0] fx;
		logic [FB:0] fy;
		logic signed [VW-1:0] tl, tr, bl, br;
		logic mtl, mtr, mbl, mbr;
	} cell_t;

	typedef struct {
		logic signed [VW-1:0] value;
		logic missing;
	} interp_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [FB:0] frac_x, frac_y;
	logic signed [VW-1:0] top_left, top_right, bottom_left, bottom_right;
	logic top_left_missing, top_right_missing, bottom_left_missing, bottom_right_missing;
	logic done;
	logic signed [VW-1:0] result_value;
	logic result_missing;

	interp_t expected_results[$];
	int mismatch_count;
	int sent_count;
	int checked_count;
	int idle_percent;
	int watchdog;

	bilinear_interp_missing_aware_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.frac_x(frac_x), .frac_y(frac_y),
		.top_left(top_left), .top_right(top_right),
		.bottom_left(bottom_left), .bottom_right(bottom_right),
		.top_left_missing(top_left_missing), .top_right_missing(top_right_missing),
		.bottom_left_missing(bottom_left_missing),
		.bottom_right_missing(bottom_right_missing),
		.done(done), .result_value(result_value), .result_missing(result_missing)
	);

	// Clock with a period of 12.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Rounded, saturated quotient of an exact signed sum by a positive weight.
	function automatic logic signed [VW-1:0] round_divide(logic signed [127:0] acc,
			longint unsigned d);
		logic neg;
		logic [127:0] mag, q, r;
		logic [127:0] lim;
		neg = acc[127];
		mag = neg ? -acc : acc;
		q = mag / d;
		r = mag % d;
		if (r >= d - r)
			q = q + 1;
		lim = (128'd1 << (VW - 1)) - (neg ? 0 : 1);
		if (q > lim)
			q = lim;
		return neg ? -q[VW-1:0] : q[VW-1:0];
	endfunction

	// Blend along one cell edge; a missing end is allowed only at the other end.
	function automatic interp_t edge_value(longint unsigned f, logic signed [VW-1:0] a,
			logic ma, logic signed [VW-1:0] b, logic mb);
		interp_t res;
		logic signed [127:0] acc;
		res.value = '0;
		res.missing = 1'b1;
		if (ma) begin
			if (f != UNIT || mb)
				return res;
			acc = 128'(signed'(b)) * UNIT;
		end else if (mb) begin
			if (f != 0)
				return res;
			acc = 128'(signed'(a)) * UNIT;
		end else begin
			acc = 128'(signed'(a)) * (UNIT - f) + 128'(signed'(b)) * f;
		end
		res.value = round_divide(acc, UNIT);
		res.missing = 1'b0;
		return res;
	endfunction

	// Expected interpolation of one cell.
	function automatic interp_t interpolate(cell_t c);
		interp_t res;
		longint unsigned dx, dy, wbl, wbr, wtl, wtr, wsum;
		logic signed [127:0] acc;
		int nmiss;
		dx = c.fx > UNIT ? UNIT : c.fx;
		dy = c.fy > UNIT ? UNIT : c.fy;
		wbl = (UNIT - dx) * (UNIT - dy);
		wbr = dx * (UNIT - dy);
		wtl = (UNIT - dx) * dy;
		wtr = dx * dy;
		nmiss = int'(c.mtl) + int'(c.mtr) + int'(c.mbl) + int'(c.mbr);
		res.value = '0;
		res.missing = 1'b1;
		if (nmiss == 0) begin
			acc = 128'(signed'(c.bl)) * wbl + 128'(signed'(c.br)) * wbr
				+ 128'(signed'(c.tl)) * wtl + 128'(signed'(c.tr)) * wtr;
			res.value = round_divide(acc, UNIT * UNIT);
			res.missing = 1'b0;
		end else if (dy == 0) begin
			res = edge_value(dx, c.bl, c.mbl, c.br, c.mbr);
		end else if (dy == UNIT) begin
			res = edge_value(dx, c.tl, c.mtl, c.tr, c.mtr);
		end else if (dx == 0) begin
			res = edge_value(dy, c.bl, c.mbl, c.tl, c.mtl);
		end else if (dx == UNIT) begin
			res = edge_value(dy, c.br, c.mbr, c.tr, c.mtr);
		end else if (nmiss == 1) begin
			acc = 0;
			wsum = 0;
			if (!c.mbl) begin acc += 128'(signed'(c.bl)) * wbl; wsum += wbl; end
			if (!c.mbr) begin acc += 128'(signed'(c.br)) * wbr; wsum += wbr; end
			if (!c.mtl) begin acc += 128'(signed'(c.tl)) * wtl; wsum += wtl; end
			if (!c.mtr) begin acc += 128'(signed'(c.tr)) * wtr; wsum += wtr; end
			if (wsum != 0) begin
				res.value = round_divide(acc, wsum);
				res.missing = 1'b0;
			end
		end
		if (res.missing)
			res.value = '0;
		return res;
	endfunction

	// Print one mismatch line and count it.
	task automatic report_mismatch(string what, longint got, longint want);
		mismatch_count++;
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
			checked_count);
	endtask

	// Drive one cell and wait for its transfer, with optional idle cycles first.
	task automatic send_cell(cell_t c);
		while ($urandom_range(99) < idle_percent) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		frac_x <= c.fx;
		frac_y <= c.fy;
		top_left <= c.tl;
		top_right <= c.tr;
		bottom_left <= c.bl;
		bottom_right <= c.br;
		top_left_missing <= c.mtl;
		top_right_missing <= c.mtr;
		bottom_left_missing <= c.mbl;
		bottom_right_missing <= c.mbr;
		do
			@(posedge clk);
		while (busy);
		expected_results.push_back(interpolate(c));
		sent_count++;
	endtask

	// Random corner value, often near the extremes.
	function automatic logic signed [VW-1:0] random_value();
		case ($urandom_range(5))
			0: return {1'b0, {(VW-1){1'b1}}};
			1: return {1'b1, {(VW-1){1'b0}}};
			2: return VW'($urandom_range(200000) - 100000);
			default: return VW'($urandom);
		endcase
	endfunction

	// Random offset, weighted toward the edges and over-range codes.
	function automatic logic [FB:0] random_offset();
		case ($urandom_range(7))
			0: return '0;
			1: return OFS_ONE;
			2: return (FB+1)'($urandom_range((1 << (FB + 1)) - 1, UNIT + 1));
			default: return (FB+1)'($urandom_range(UNIT - 1, 1));
		endcase
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		c.fx = random_offset();
		c.fy = random_offset();
		c.tl = random_value();
		c.tr = random_value();
		c.bl = random_value();
		c.br = random_value();
		// Mostly zero or one missing corner, where the interesting paths are.
		case ($urandom_range(3))
			0: {c.mtl, c.mtr, c.mbl, c.mbr} = 4'b0000;
			1, 2: {c.mtl, c.mtr, c.mbl, c.mbr} = 4'b0001 << $urandom_range(3);
			default: {c.mtl, c.mtr, c.mbl, c.mbr} = 4'($urandom);
		endcase
		return c;
	endfunction

	function automatic cell_t make_cell(logic [FB:0] fx, logic [FB:0] fy,
			logic signed [VW-1:0] v, logic [3:0] miss);
		cell_t c;
		c.fx = fx;
		c.fy = fy;
		c.tl = v;
		c.tr = -v;
		c.bl = v >>> 1;
		c.br = VW'(32'sh0001_8000);
		{c.mtl, c.mtr, c.mbl, c.mbr} = miss;
		return c;
	endfunction

	// Corners of the offsets and values, every edge and a selection of missing patterns.
	task automatic test_directed();
		logic signed [VW-1:0] vmax, vmin;
		cell_t c;
		vmax = {1'b0, {(VW-1){1'b1}}};
		vmin = {1'b1, {(VW-1){1'b0}}};
		idle_percent = 0;
		send_cell(make_cell('0, '0, vmax, 4'b0000));
		send_cell(make_cell(OFS_ONE, OFS_ONE, vmin, 4'b0000));
		send_cell(make_cell({(FB+1){1'b1}}, {(FB+1){1'b1}}, vmin, 4'b0000));
		send_cell(make_cell((FB+1)'(UNIT / 2), (FB+1)'(UNIT / 2), VW'(3), 4'b0000));
		// Saturation: all corners at the same extreme.
		c = make_cell((FB+1)'(UNIT / 3), (FB+1)'(UNIT / 5), vmax, 4'b0000);
		c.tr = vmax; c.bl = vmax; c.br = vmax;
		send_cell(c);
		// Edge blends with a missing end at the allowed and disallowed offsets.
		send_cell(make_cell(OFS_ONE, '0, vmax, 4'b0010));
		send_cell(make_cell((FB+1)'(UNIT - 1), '0, vmax, 4'b0010));
		send_cell(make_cell('0, '0, vmax, 4'b0001));
		send_cell(make_cell('0, OFS_ONE, vmin, 4'b0100));
		send_cell(make_cell((FB+1)'(1), OFS_ONE, vmin, 4'b0100));
		send_cell(make_cell('0, (FB+1)'(UNIT / 4), vmax, 4'b0100));
		send_cell(make_cell(OFS_ONE, (FB+1)'(UNIT / 4), vmax, 4'b0001));
		send_cell(make_cell(OFS_ONE, '0, vmax, 4'b0011));
		// Exactly one missing corner inside the cell, each corner in turn.
		for (int i = 0; i < 4; i++)
			send_cell(make_cell((FB+1)'(UNIT / 3), (FB+1)'(UNIT * 2 / 3), vmin,
				4'b0001 << i));
		// Offsets just inside the far corner, where the remaining weight is close to one.
		send_cell(make_cell(OFS_ONE - 1'b1, OFS_ONE - 1'b1, vmax, 4'b1000));
		send_cell(make_cell(OFS_ONE - 1'b1, OFS_ONE - 1'b1, vmin, 4'b1000));
		// Two or more missing, inside the cell and at a cell corner.
		send_cell(make_cell((FB+1)'(UNIT / 2), (FB+1)'(UNIT / 2), vmax, 4'b1001));
		send_cell(make_cell((FB+1)'(UNIT / 2), (FB+1)'(UNIT / 2), vmax, 4'b1111));
		send_cell(make_cell('0, '0, vmax, 4'b1111));
	endtask

	// Random cells under one idle setting.
	task automatic test_random(int count, int idle);
		idle_percent = idle;
		for (int i = 0; i < count; i++)
			send_cell(random_cell());
	endtask

	// Compare each result strobe with the oldest expectation.
	always @(posedge clk) begin
		interp_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", result_value, 0);
			end else begin
				want = expected_results.pop_front();
				if (result_missing !== want.missing)
					report_mismatch("result_missing", result_missing, want.missing);
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
			end
			checked_count++;
		end
	end

	// Watchdog on cycles with no transfer in either direction.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		sent_count = 0;
		checked_count = 0;
		idle_percent = 0;
		watchdog = 0;
		arst_n = 1'b0;
		start = 1'b0;
		frac_x = '0;
		frac_y = '0;
		top_left = '0;
		top_right = '0;
		bottom_left = '0;
		bottom_right = '0;
		top_left_missing = 1'b0;
		top_right_missing = 1'b0;
		bottom_left_missing = 1'b0;
		bottom_right_missing = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250, 0);
		test_random(170, 70);
		test_random(160, 29);
		test_random(150, 0);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("Sent %0d cells: all edges, missing patterns, saturation, idle mixes.",
			sent_count);
		$display("Checked %0d results, %0d mismatches.", checked_count, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
